/* src/hupg_pkg.sv */
`default_nettype none

package hupg_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
    logic       end_of_chunk;
  } in_word_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] payload_byte;
  } out_word_t;

  localparam logic [1:0] KIND_HEADER     = 2'd0;
  localparam logic [1:0] KIND_PAYLOAD    = 2'd1;
  localparam logic [1:0] KIND_REJECTED   = 2'd2;
  localparam logic [1:0] KIND_INCOMPLETE = 2'd3;

  localparam logic [7:0] CH_CR  = 8'h0d;
  localparam logic [7:0] CH_LF  = 8'h0a;
  localparam logic [7:0] CH_SP  = 8'h20;
  localparam logic [7:0] CH_TAB = 8'h09;

  localparam int unsigned MethodLen = 3;
  localparam int unsigned NameLen   = 8;
  localparam int unsigned ValueLen  = 9;

  localparam logic [7:0] METHOD_TEXT [MethodLen] = '{8'h47, 8'h45, 8'h54};
  localparam logic [7:0] NAME_TEXT [NameLen] =
    '{8'h55, 8'h70, 8'h67, 8'h72, 8'h61, 8'h64, 8'h65, 8'h3a};
  localparam logic [7:0] VALUE_TEXT [ValueLen] =
    '{8'h77, 8'h65, 8'h62, 8'h73, 8'h6f, 8'h63, 8'h6b, 8'h65, 8'h74};

  // ascii upper case to lower case, other bytes unchanged
  function automatic logic [7:0] fold_case(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h41 && c <= 8'h5a) begin
      r = c + 8'd32;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* src/http_upgrade_header_check_strip.sv */
// path: a taken word waits in the input register until the output register
//   can take its result word; an output stall holds it there
// throughput: one word per cycle unless the output stalls; combinational match
// reset: asynchronous, active low; clears the valid flags of both pipeline
//   registers and the header parse state, and sets check_q to 1
`default_nettype none

module http_upgrade_header_check_strip (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire hupg_pkg::in_word_t in_word_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output hupg_pkg::out_word_t     out_word_o,
  input  wire logic               cfg_we_i,
  input  wire logic               cfg_wdata_i
);

  typedef enum logic [6:0] {
    PH_METHOD   = 7'b0000001,
    PH_SKIP     = 7'b0000010,
    PH_NAME     = 7'b0000100,
    PH_BLANKS   = 7'b0001000,
    PH_VALUE    = 7'b0010000,
    PH_PAYLOAD  = 7'b0100000,
    PH_REJECTED = 7'b1000000
  } phase_e;

  logic                check_q;
  logic                in_valid_q;
  hupg_pkg::in_word_t  in_word_q;
  logic                out_valid_q;
  hupg_pkg::out_word_t out_word_q;
  hupg_pkg::out_word_t res;
  logic                advance;

  phase_e     phase_q, phase_d;
  logic [3:0] match_q, match_d;
  logic [1:0] term_q, term_d;
  logic       found_q, found_d;
  logic [3:0] vlen_q, vlen_d;

  assign advance     = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o  = in_valid_q && !advance;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  always_comb begin
    logic [7:0] b;
    phase_e     ph;
    logic [3:0] mp;
    logic [1:0] tc;
    logic       fnd;
    logic [3:0] vl;
    logic       prev_cr;
    logic       line_end;
    logic       done;
    logic       ok;
    logic       blank;

    b       = in_word_q.data_byte;
    ph      = in_word_q.first_byte ? PH_METHOD : phase_q;
    mp      = in_word_q.first_byte ? 4'd0 : match_q;
    tc      = in_word_q.first_byte ? 2'd0 : term_q;
    fnd     = in_word_q.first_byte ? 1'b0 : found_q;
    vl      = in_word_q.first_byte ? 4'd0 : vlen_q;
    prev_cr = tc[0];
    line_end = prev_cr && (b == hupg_pkg::CH_LF);
    blank   = (b == hupg_pkg::CH_SP) || (b == hupg_pkg::CH_TAB);
    done    = 1'b0;
    ok      = 1'b1;
    res.kind         = hupg_pkg::KIND_HEADER;
    res.payload_byte = 8'd0;

    phase_d = ph;
    match_d = mp;
    term_d  = tc;
    found_d = fnd;
    vlen_d  = vl;

    if (ph == PH_PAYLOAD) begin
      res.kind         = hupg_pkg::KIND_PAYLOAD;
      res.payload_byte = b;
    end else if (ph != PH_METHOD && ph != PH_SKIP && ph != PH_NAME &&
                 ph != PH_BLANKS && ph != PH_VALUE) begin
      res.kind = hupg_pkg::KIND_REJECTED;
    end else begin
      // terminator tracking, crlf crlf
      if (b == hupg_pkg::CH_CR) begin
        term_d = (tc == 2'd2) ? 2'd3 : 2'd1;
      end else if (b == hupg_pkg::CH_LF) begin
        if (tc == 2'd1) begin
          term_d = 2'd2;
        end else begin
          done   = (tc == 2'd3);
          term_d = 2'd0;
        end
      end else begin
        term_d = 2'd0;
      end

      if (check_q && !done) begin
        unique case (ph)
          PH_METHOD: begin
            if (mp < 4'(hupg_pkg::MethodLen) &&
                hupg_pkg::fold_case(b) ==
                hupg_pkg::fold_case(hupg_pkg::METHOD_TEXT[mp[1:0]])) begin
              match_d = mp + 4'd1;
              if (mp == 4'(hupg_pkg::MethodLen - 1)) begin
                phase_d = PH_SKIP;
                match_d = 4'd0;
              end
            end else begin
              ok = 1'b0;
            end
          end
          PH_SKIP: begin
            if (line_end && !fnd) begin
              phase_d = PH_NAME;
              match_d = 4'd0;
            end
          end
          PH_NAME: begin
            if (mp < 4'(hupg_pkg::NameLen) &&
                hupg_pkg::fold_case(b) ==
                hupg_pkg::fold_case(hupg_pkg::NAME_TEXT[mp[2:0]])) begin
              match_d = mp + 4'd1;
              if (mp == 4'(hupg_pkg::NameLen - 1)) begin
                phase_d = PH_BLANKS;
              end
            end else begin
              phase_d = PH_SKIP;
              match_d = 4'd0;
            end
          end
          PH_BLANKS: begin
            if (prev_cr) begin
              if (line_end && mp == 4'(hupg_pkg::NameLen)) begin
                phase_d = PH_NAME;
                match_d = 4'd0;
              end else begin
                ok = 1'b0;
              end
            end else if (blank) begin
              match_d = 4'(hupg_pkg::NameLen + 1);
            end else if (b == hupg_pkg::CH_CR) begin
              ok = 1'b1;
            end else if (b == hupg_pkg::VALUE_TEXT[0]) begin
              phase_d = PH_VALUE;
              vlen_d  = 4'd1;
            end else begin
              ok = 1'b0;
            end
          end
          PH_VALUE: begin
            if (prev_cr) begin
              if (line_end) begin
                found_d = 1'b1;
                phase_d = PH_SKIP;
                match_d = 4'd0;
              end else begin
                ok = 1'b0;
              end
            end else if (b == hupg_pkg::CH_CR) begin
              ok = 1'b1;
            end else if (vl < 4'(hupg_pkg::ValueLen) &&
                         b == hupg_pkg::VALUE_TEXT[vl]) begin
              vlen_d = vl + 4'd1;
            end else begin
              ok = 1'b0;
            end
          end
          default: begin
            ok = 1'b0;
          end
        endcase
      end

      if (done) begin
        if (check_q && !fnd) begin
          phase_d  = PH_REJECTED;
          res.kind = hupg_pkg::KIND_REJECTED;
        end else begin
          phase_d = PH_PAYLOAD;
        end
      end else if (!ok) begin
        phase_d  = PH_REJECTED;
        res.kind = hupg_pkg::KIND_REJECTED;
      end else if (in_word_q.end_of_chunk) begin
        res.kind = hupg_pkg::KIND_INCOMPLETE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      check_q <= 1'b1;
    end else if (cfg_we_i) begin
      check_q <= cfg_wdata_i;
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_valid_i && !in_stall_o) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_word_q <= in_word_i;
    end
  end

  // parse state, updated as each word moves to the output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_METHOD;
      match_q <= 4'd0;
      term_q  <= 2'd0;
      found_q <= 1'b0;
      vlen_q  <= 4'd0;
    end else if (advance) begin
      phase_q <= phase_d;
      match_q <= match_d;
      term_q  <= term_d;
      found_q <= found_d;
      vlen_q  <= vlen_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_word_q <= res;
    end
  end

endmodule

`default_nettype wire
